FILE: sv/hsfd_pkg.sv
// ----------------------------------------------------------------------------
// hsfd_pkg: shared types and constants of the humidity frame decoder
// Frame byte positions, status codes, CRC-8 step and conversion constants.
// ----------------------------------------------------------------------------
`default_nettype none

package hsfd_pkg;

    // Byte positions inside a measurement frame
    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    // Frame status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_TEMP_CRC = 2'd1;
    localparam logic [1:0] STATUS_HUM_CRC  = 2'd2;

    // CRC-8, MSB first
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Conversion: floor(scale * raw / 65535)
    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [16:0] WORD_ALL_ONES = 17'd65535;

    // Request queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One decoded frame, waiting for conversion
    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [15:0] raw_humidity;
        logic [1:0]  frame_status;
    } job_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: sv/humidity_sensor_frame_decoder_unit.sv
// Path: a frame's request is written into the queue as its sixth byte is accepted,
//   then passes the scale multiply register and the divide-by-65535 correction into
//   the output register; a stalled result port can hold it on the way.
// Throughput: one byte per cycle while the queue has room; one result per complete frame.
//   Converter: one request per cycle unless the result port stalls, the only hold on bytes.
// Reset (aresetn low, synchronous): byte position to zero, CRC to 0xFF, queue empty,
//   no result pending.
// ----------------------------------------------------------------------------
// humidity_sensor_frame_decoder_unit: temperature/humidity frame decoder
// Front checks CRC-8 over the two words of each six-byte frame, a short queue
// holds complete frames, back converts raw words to centi-units.
// ----------------------------------------------------------------------------
`default_nettype none

module humidity_sensor_frame_decoder_unit (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // byte input
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_rx_byte,
    input  wire logic               s_frame_start,
    // result output
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [14:0]      m_temperature_centi,
    output logic        [13:0]      m_humidity_centi,
    output logic        [15:0]      m_raw_temperature,
    output logic        [15:0]      m_raw_humidity,
    output logic        [1:0]       m_frame_status
);
    import hsfd_pkg::*;

    logic in_accept;
    logic push_valid, push_ready;
    job_t push_data;
    logic pop_valid, pop_ready;
    job_t pop_data;

    // The byte input only waits when the queue is full; the front itself
    // never stalls. A frame's last byte then always finds room for its request.
    assign s_ready   = push_ready;
    assign in_accept = s_valid && s_ready;

    hsfd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .rx_byte     (s_rx_byte),
        .frame_start (s_frame_start),
        .push_data   (push_data),
        .push_valid  (push_valid)
    );

    hsfd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Back end: multiply stage and output register; results
    // leave in frame order.
    hsfd_back u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .pop_valid           (pop_valid),
        .pop_ready           (pop_ready),
        .pop_data            (pop_data),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_temperature_centi (m_temperature_centi),
        .m_humidity_centi    (m_humidity_centi),
        .m_raw_temperature   (m_raw_temperature),
        .m_raw_humidity      (m_raw_humidity),
        .m_frame_status      (m_frame_status)
    );

    // every request the front raises must find room in the queue
    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> push_ready)
        else $error("frame request dropped at queue");

endmodule

`default_nettype wire

FILE: sv/hsfd_front.sv
// ----------------------------------------------------------------------------
// hsfd_front: frame byte intake
// Tracks the byte position, runs the CRC-8 and pushes one request per frame.
// ----------------------------------------------------------------------------
`default_nettype none

module hsfd_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_accept,
    input  wire logic [7:0]    rx_byte,
    input  wire logic          frame_start,
    output hsfd_pkg::job_t     push_data,
    output logic               push_valid
);
    import hsfd_pkg::*;

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [7:0]  high_reg, high_next;
    logic [15:0] temp_word_reg, temp_word_next;
    logic [15:0] hum_word_reg, hum_word_next;
    logic        tgood_reg, tgood_next;

    logic        restart;
    logic [2:0]  pos_eff;
    logic [7:0]  crc_base;
    logic [7:0]  crc_stepped;
    logic        hgood;

    assign restart     = frame_start || (pos_reg > POS_H_CRC);
    assign pos_eff     = restart ? POS_T_HI : pos_reg;
    assign crc_base    = restart ? CRC_INIT : crc_reg;
    assign crc_stepped = crc8_update(crc_base, rx_byte);
    assign hgood       = (crc_base == rx_byte);

    always_comb begin
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        high_next      = high_reg;
        temp_word_next = temp_word_reg;
        hum_word_next  = hum_word_reg;
        tgood_next     = tgood_reg;
        push_valid     = 1'b0;
        if (in_accept) begin
            pos_next = pos_eff + 3'd1;
            unique case (pos_eff)
                POS_T_HI, POS_H_HI: begin
                    crc_next  = crc_stepped;
                    high_next = rx_byte;
                end
                POS_T_LO: begin
                    crc_next       = crc_stepped;
                    temp_word_next = {high_reg, rx_byte};
                end
                POS_T_CRC: begin
                    tgood_next = hgood;
                    crc_next   = CRC_INIT;
                end
                POS_H_LO: begin
                    crc_next      = crc_stepped;
                    hum_word_next = {high_reg, rx_byte};
                end
                default: begin
                    // last byte: humidity CRC, frame complete
                    crc_next   = CRC_INIT;
                    pos_next   = POS_T_HI;
                    push_valid = 1'b1;
                end
            endcase
        end
    end

    // temperature check has priority over humidity
    always_comb begin
        push_data.raw_temperature = temp_word_reg;
        push_data.raw_humidity    = hum_word_reg;
        if (!tgood_reg) begin
            push_data.frame_status = STATUS_TEMP_CRC;
        end else if (!hgood) begin
            push_data.frame_status = STATUS_HUM_CRC;
        end else begin
            push_data.frame_status = STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= POS_T_HI;
            crc_reg       <= CRC_INIT;
            high_reg      <= 8'd0;
            temp_word_reg <= 16'd0;
            hum_word_reg  <= 16'd0;
            tgood_reg     <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            high_reg      <= high_next;
            temp_word_reg <= temp_word_next;
            hum_word_reg  <= hum_word_next;
            tgood_reg     <= tgood_next;
        end
    end

    a_push_rewinds: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |=> (pos_reg == POS_T_HI) && (crc_reg == CRC_INIT))
        else $error("front did not rewind after a complete frame");

endmodule

`default_nettype wire

FILE: sv/hsfd_queue.sv
// ----------------------------------------------------------------------------
// hsfd_queue: request queue
// Small FIFO of decoded frames between the byte intake and the converter.
// ----------------------------------------------------------------------------
`default_nettype none

module hsfd_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push_valid,
    input  wire hsfd_pkg::job_t push_data,
    output logic               push_ready,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output hsfd_pkg::job_t     pop_data
);
    import hsfd_pkg::*;

    job_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");

endmodule

`default_nettype wire

FILE: sv/hsfd_back.sv
// ----------------------------------------------------------------------------
// hsfd_back: unit conversion
// Scale multiply, then divide by 65535 with a shift and one correction.
// ----------------------------------------------------------------------------
`default_nettype none

module hsfd_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                pop_valid,
    output logic                     pop_ready,
    input  wire hsfd_pkg::job_t      pop_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic signed [14:0]       m_temperature_centi,
    output logic        [13:0]       m_humidity_centi,
    output logic        [15:0]       m_raw_temperature,
    output logic        [15:0]       m_raw_humidity,
    output logic        [1:0]        m_frame_status
);
    import hsfd_pkg::*;

    // stage 1: products
    logic        s1_valid_reg, s1_valid_next;
    job_t        s1_job_reg;
    logic [30:0] s1_tprod_reg;
    logic [29:0] s1_hprod_reg;

    // stage 2: output register
    logic        out_valid_reg, out_valid_next;
    logic signed [14:0] out_temp_reg;
    logic [13:0] out_hum_reg;
    job_t        out_job_reg;

    logic        out_free, s1_adv, s1_free, take;

    logic [14:0] tq0, tq;
    logic [16:0] tr;
    logic [13:0] hq0, hq;
    logic [16:0] hr;

    assign out_free  = !out_valid_reg || m_ready;
    assign s1_adv    = s1_valid_reg && out_free;
    assign s1_free   = !s1_valid_reg || s1_adv;
    assign pop_ready = s1_free;
    assign take      = pop_valid && s1_free;

    // x / 65535 = (x >> 16) plus one when (x mod 65536) + (x >> 16) reaches 65535
    assign tq0 = s1_tprod_reg[30:16];
    assign tr  = {1'b0, s1_tprod_reg[15:0]} + 17'(tq0);
    assign tq  = tq0 + 15'(tr >= WORD_ALL_ONES);
    assign hq0 = s1_hprod_reg[29:16];
    assign hr  = {1'b0, s1_hprod_reg[15:0]} + 17'(hq0);
    assign hq  = hq0 + 14'(hr >= WORD_ALL_ONES);

    always_comb begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (out_free) begin
            out_valid_next = s1_valid_reg;
        end
        if (s1_free) begin
            s1_valid_next = pop_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            s1_job_reg   <= pop_data;
            s1_tprod_reg <= 31'(pop_data.raw_temperature) * 31'(TEMP_SCALE);
            s1_hprod_reg <= 30'(pop_data.raw_humidity) * 30'(HUM_SCALE);
        end
        if (s1_adv) begin
            out_job_reg <= s1_job_reg;
            if (s1_job_reg.frame_status == STATUS_OK) begin
                out_temp_reg <= $signed(tq - TEMP_OFFSET);
                out_hum_reg  <= hq;
            end else begin
                out_temp_reg <= '0;
                out_hum_reg  <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_temperature_centi = out_temp_reg;
    assign m_humidity_centi    = out_hum_reg;
    assign m_raw_temperature   = out_job_reg.raw_temperature;
    assign m_raw_humidity      = out_job_reg.raw_humidity;
    assign m_frame_status      = out_job_reg.frame_status;

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_job_reg.frame_status != STATUS_OK))
            |-> (out_temp_reg == '0) && (out_hum_reg == '0))
        else $error("converted values not zero on CRC error");

    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !out_free) |=> s1_valid_reg && $stable(s1_tprod_reg)
            && $stable(s1_hprod_reg))
        else $error("stage 1 lost a request while stalled");

endmodule

`default_nettype wire

FILE: tb/hsfd_result_checker.sv
// ----------------------------------------------------------------------------
// hsfd_result_checker: frame decode predictor and result comparator
// Watches both channels of the frame decoder. Runs its own CRC-8 and
// centi-unit conversion on each accepted byte, queues the decoded frame,
// and compares every accepted result against the oldest queued frame.
// ----------------------------------------------------------------------------
module hsfd_result_checker
    import hsfd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    input  logic               s_frame_start,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [14:0] m_temperature_centi,
    input  logic [13:0]        m_humidity_centi,
    input  logic [15:0]        m_raw_temperature,
    input  logic [15:0]        m_raw_humidity,
    input  logic [1:0]         m_frame_status,
    output int                 fail_count,
    output int                 pending_results,
    output int                 bytes_taken,
    output int                 ok_frames,
    output int                 temp_crc_frames,
    output int                 hum_crc_frames
);

    typedef struct {
        logic signed [14:0] temperature_centi;
        logic [13:0]        humidity_centi;
        logic [15:0]        raw_temperature;
        logic [15:0]        raw_humidity;
        logic [1:0]         frame_status;
    } decoded_frame_t;

    decoded_frame_t frames_due[$];

    // decoder state as the block should hold it
    logic [2:0]  next_pos;
    logic [7:0]  word_crc;
    logic [7:0]  hi_byte;
    logic [15:0] temp_word;
    logic [15:0] hum_word;
    logic        temp_crc_ok;

    // bit-serial CRC-8, feedback form
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] d);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[7] ^ d[i];
            c  = {c[6:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic take_byte(input logic [7:0] rx, input logic st);
        decoded_frame_t fr;
        logic [2:0]     pos;
        logic           hum_crc_ok;
        int unsigned    t_q;
        int unsigned    h_q;
        pos = next_pos;
        if (st || pos > POS_H_CRC) begin
            pos      = POS_T_HI;
            word_crc = CRC_INIT;
        end
        next_pos = pos + 3'd1;
        case (pos)
            POS_T_HI, POS_H_HI: begin
                word_crc = crc8_step(word_crc, rx);
                hi_byte  = rx;
            end
            POS_T_LO: begin
                word_crc  = crc8_step(word_crc, rx);
                temp_word = {hi_byte, rx};
            end
            POS_T_CRC: begin
                temp_crc_ok = (word_crc == rx);
                word_crc    = CRC_INIT;
            end
            POS_H_LO: begin
                word_crc = crc8_step(word_crc, rx);
                hum_word = {hi_byte, rx};
            end
            default: begin
                // sixth byte closes the frame
                hum_crc_ok           = (word_crc == rx);
                word_crc             = CRC_INIT;
                next_pos             = POS_T_HI;
                fr.raw_temperature   = temp_word;
                fr.raw_humidity      = hum_word;
                fr.temperature_centi = '0;
                fr.humidity_centi    = '0;
                if (!temp_crc_ok) begin
                    fr.frame_status = STATUS_TEMP_CRC;
                end else if (!hum_crc_ok) begin
                    fr.frame_status = STATUS_HUM_CRC;
                end else begin
                    fr.frame_status      = STATUS_OK;
                    t_q                  = (32'd17500 * temp_word) / 32'd65535;
                    h_q                  = (32'd10000 * hum_word) / 32'd65535;
                    fr.temperature_centi = 15'(int'(t_q) - 4500);
                    fr.humidity_centi    = 14'(h_q);
                end
                frames_due.push_back(fr);
            end
        endcase
    endtask

    task automatic check_result();
        decoded_frame_t want;
        if (frames_due.size() == 0) begin
            $error("unexpected result: raw_temperature %h raw_humidity %h status %0d",
                   m_raw_temperature, m_raw_humidity, m_frame_status);
            fail_count++;
        end else begin
            want = frames_due.pop_front();
            case (want.frame_status)
                STATUS_OK:       ok_frames++;
                STATUS_TEMP_CRC: temp_crc_frames++;
                default:         hum_crc_frames++;
            endcase
            if (m_temperature_centi !== want.temperature_centi) begin
                $error("temperature_centi: expected %0d, got %0d",
                       want.temperature_centi, m_temperature_centi);
                fail_count++;
            end
            if (m_humidity_centi !== want.humidity_centi) begin
                $error("humidity_centi: expected %0d, got %0d",
                       want.humidity_centi, m_humidity_centi);
                fail_count++;
            end
            if (m_raw_temperature !== want.raw_temperature) begin
                $error("raw_temperature: expected %h, got %h",
                       want.raw_temperature, m_raw_temperature);
                fail_count++;
            end
            if (m_raw_humidity !== want.raw_humidity) begin
                $error("raw_humidity: expected %h, got %h",
                       want.raw_humidity, m_raw_humidity);
                fail_count++;
            end
            if (m_frame_status !== want.frame_status) begin
                $error("frame_status: expected %0d, got %0d",
                       want.frame_status, m_frame_status);
                fail_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            next_pos        = POS_T_HI;
            word_crc        = CRC_INIT;
            hi_byte         = '0;
            temp_word       = '0;
            hum_word        = '0;
            temp_crc_ok     = 1'b0;
            frames_due.delete();
            fail_count      = 0;
            pending_results = 0;
            bytes_taken     = 0;
            ok_frames       = 0;
            temp_crc_frames = 0;
            hum_crc_frames  = 0;
        end else begin
            if (s_valid && s_ready) begin
                take_byte(s_rx_byte, s_frame_start);
                bytes_taken++;
            end
            if (m_valid && m_ready) begin
                check_result();
            end
            pending_results = frames_due.size();
        end
    end

endmodule

FILE: tb/tb_humidity_sensor_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_humidity_sensor_frame_decoder_unit: frame decoder testbench
// Feeds byte requests (directed edge frames, then random frames with good,
// bad and truncated CRC sequences plus noise) under several idle/stall mixes,
// and leaves prediction and comparison to hsfd_result_checker.
// ----------------------------------------------------------------------------
module tb_humidity_sensor_frame_decoder_unit;
    import hsfd_pkg::*;

    // longest legal quiet stretch is the output hold-off; this is far above it
    localparam int WATCHDOG_LIMIT     = 5000;
    localparam int OUTPUT_HOLD_CYCLES = 400;
    // drain time after the last phase, before the verdict
    localparam int DRAIN_CYCLES       = 8;
    localparam int PHASE_BYTES        = 456;
    // per phase: sender idle percent, receiver stall percent
    localparam int SEND_IDLE_MIX [4]  = '{0, 82, 0, 15};
    localparam int RECV_STALL_MIX [4] = '{0, 0, 82, 15};

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic [7:0]         s_rx_byte     = '0;
    logic               s_frame_start = 1'b0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic signed [14:0] m_temperature_centi;
    logic [13:0]        m_humidity_centi;
    logic [15:0]        m_raw_temperature;
    logic [15:0]        m_raw_humidity;
    logic [1:0]         m_frame_status;

    int fail_count;
    int pending_results;
    int bytes_taken;
    int ok_frames;
    int temp_crc_frames;
    int hum_crc_frames;

    int send_idle_pct       = 0;
    int recv_stall_pct      = 0;
    int bytes_pushed        = 0;
    int quiet_cycles        = 0;
    bit hold_output_request = 1'b0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    humidity_sensor_frame_decoder_unit dut (.*);

    hsfd_result_checker u_checker (.*);

    // ------------------------------------------------------------------
    // Watchdog: counts cycles where neither channel moves a request.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no request moved for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, pending_results);
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random back-pressure at the current stall rate. A
    // hold-off request from the stimulus drops ready for a long stretch,
    // counted here, so the internal queue fills and s_ready goes low.
    // ------------------------------------------------------------------
    initial begin
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_output_request) begin
                hold_output_request = 1'b0;
                m_ready <= 1'b0;
                repeat (OUTPUT_HOLD_CYCLES) @(negedge aclk);
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Byte side
    // ------------------------------------------------------------------

    // One byte request. Gaps are inserted before it at the sender idle rate;
    // valid is held with a stable payload until the handshake.
    task automatic push_byte(input logic [7:0] rx, input logic st);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_rx_byte     <= rx;
        s_frame_start <= st;
        do @(posedge aclk); while (!s_ready);
        bytes_pushed++;
    endtask

    // Sender goes quiet until every complete frame sent so far has come back.
    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending_results == 0);
    endtask

    // Edge words show up often so the conversion extremes get hit.
    function automatic logic [15:0] pick_word();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Builds a six-byte frame with proper CRCs, optionally corrupts either
    // CRC, and sends only the first 'keep' bytes (short frames get dropped
    // by the next frame start, or run into the following bytes if none).
    task automatic send_frame(input logic [15:0] t_word, input logic [15:0] h_word,
                              input bit t_bad, input bit h_bad, input bit mark_start,
                              input int keep);
        logic [7:0] frame [6];
        frame[0] = t_word[15:8];
        frame[1] = t_word[7:0];
        frame[2] = crc8_update(crc8_update(CRC_INIT, frame[0]), frame[1]);
        frame[3] = h_word[15:8];
        frame[4] = h_word[7:0];
        frame[5] = crc8_update(crc8_update(CRC_INIT, frame[3]), frame[4]);
        if (t_bad) begin
            frame[2] ^= 8'($urandom_range(255, 1));
        end
        if (h_bad) begin
            frame[5] ^= 8'($urandom_range(255, 1));
        end
        for (int i = 0; i < keep; i++) begin
            push_byte(frame[i], mark_start && (i == 0));
        end
    endtask

    // Mostly clean frames with random content; the rest are CRC failures,
    // truncated frames and stray bytes with random start flags.
    task automatic run_random_traffic(input int byte_budget);
        int stop_at;
        int pick;
        stop_at = bytes_pushed + byte_budget;
        while (bytes_pushed < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                send_frame(pick_word(), pick_word(), 1'b0, 1'b0,
                           $urandom_range(9) != 0, 6);
            end else if (pick < 85) begin
                case ($urandom_range(2))
                    0:       send_frame(pick_word(), pick_word(), 1'b1, 1'b0, 1'b1, 6);
                    1:       send_frame(pick_word(), pick_word(), 1'b0, 1'b1, 1'b1, 6);
                    default: send_frame(pick_word(), pick_word(), 1'b1, 1'b1, 1'b1, 6);
                endcase
            end else if (pick < 93) begin
                send_frame(pick_word(), pick_word(), 1'($urandom_range(1)),
                           1'($urandom_range(1)), 1'b1, $urandom_range(5, 1));
            end else begin
                repeat ($urandom_range(4, 1)) begin
                    push_byte(8'($urandom), $urandom_range(3) == 0);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: conversion extremes, missing start flag, abandoned frame,
        // both CRCs bad (temperature wins), humidity CRC bad alone.
        send_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b1, 6);
        send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0, 6);
        send_frame(16'h8000, 16'h8000, 1'b0, 1'b0, 1'b1, 1);
        send_frame(16'h1234, 16'hABCD, 1'b1, 1'b1, 1'b1, 6);
        send_frame(16'h6666, 16'h9999, 1'b0, 1'b1, 1'b1, 6);
        wait_for_results();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = SEND_IDLE_MIX[ph];
            recv_stall_pct = RECV_STALL_MIX[ph];
            // full-rate phase also gets the long output hold-off
            if (ph == 0) begin
                hold_output_request = 1'b1;
            end
            run_random_traffic(PHASE_BYTES);
            wait_for_results();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d byte requests, %0d frames: %0d clean, %0d temp CRC, %0d hum CRC.",
                 bytes_taken, ok_frames + temp_crc_frames + hum_crc_frames,
                 ok_frames, temp_crc_frames, hum_crc_frames);
        $display("Ran four idle/stall mixes with a long output hold-off and drains between.");
        if (fail_count == 0 && pending_results == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/hsfd_pkg.sv
sv/hsfd_front.sv
sv/hsfd_queue.sv
sv/hsfd_back.sv
sv/humidity_sensor_frame_decoder_unit.sv
tb/hsfd_result_checker.sv
tb/tb_humidity_sensor_frame_decoder_unit.sv
